/* rtl/tcp_pkg.sv */
// ----------------------------------------------------------------------------
// tcp_pkg
// shared types, codes and constants of the tuning command parser
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int CharW           = 8;
  localparam int ValW            = 27;
  localparam int PosW            = 6;
  localparam int MaxCommandChars = 31;
  localparam int FractionDigits  = 3;
  localparam logic [ValW-1:0] SatValue   = {ValW{1'b1}};
  localparam logic [ValW-1:0] LimitReset = ValW'(100000);

  // parse phases
  localparam logic [2:0] PhHead  = 3'd0;
  localparam logic [2:0] PhLead  = 3'd1;
  localparam logic [2:0] PhSign  = 3'd2;
  localparam logic [2:0] PhInt   = 3'd3;
  localparam logic [2:0] PhFrac  = 3'd4;
  localparam logic [2:0] PhTrail = 3'd5;
  localparam logic [2:0] PhDone  = 3'd6;
  localparam logic [2:0] PhBad   = 3'd7;

  typedef enum logic [2:0] {
    KindNone  = 3'd0,
    KindLine  = 3'd1,
    KindP     = 3'd2,
    KindI     = 3'd3,
    KindD     = 3'd4,
    KindSpeed = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    VerdictReject = 3'd0,
    VerdictLine   = 3'd1,
    VerdictP      = 3'd2,
    VerdictI      = 3'd3,
    VerdictD      = 3'd4,
    VerdictRun    = 3'd5,
    VerdictStop   = 3'd6
  } verdict_e;

  typedef enum logic [1:0] {
    CfgLineGainLimit  = 2'd0,
    CfgSpeedGainLimit = 2'd1,
    CfgSpeedLimit     = 2'd2
  } cfg_idx_e;

  // characters
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChDot   = 8'h2e;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;
  localparam logic [CharW-1:0] ChColon = 8'h3a;
  localparam logic [CharW-1:0] ChEqual = 8'h3d;
  localparam logic [CharW-1:0] ChUpD   = 8'h44;
  localparam logic [CharW-1:0] ChUpI   = 8'h49;
  localparam logic [CharW-1:0] ChUpK   = 8'h4b;
  localparam logic [CharW-1:0] ChUpP   = 8'h50;
  localparam logic [CharW-1:0] ChUpS   = 8'h53;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoI   = 8'h69;
  localparam logic [CharW-1:0] ChLoK   = 8'h6b;
  localparam logic [CharW-1:0] ChLoP   = 8'h70;
  localparam logic [CharW-1:0] ChLoZ   = 8'h7a;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             final_char;
  } in_req_t;

  typedef struct packed {
    logic [2:0]      verdict;
    logic [ValW-1:0] amount;
  } out_res_t;

  // parsed command handed from the parser to the judge
  typedef struct packed {
    logic            ok;
    logic            minus;
    kind_e           kind;
    logic [ValW-1:0] value;
  } snap_t;

endpackage

/* rtl/tcp_parser.sv */
// ----------------------------------------------------------------------------
// tcp_parser
// per-character command parser: header, sign, integer and fraction digits
// ----------------------------------------------------------------------------
module tcp_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [tcp_pkg::CharW-1:0] char_i,
  input  logic                      final_i,
  output tcp_pkg::snap_t            snap_o
);

  logic [tcp_pkg::PosW-1:0]  pos_q, pos_d, pos_nx;
  logic [2:0]                phase_q, phase_d, phase_nx;
  tcp_pkg::kind_e            kind_q, kind_d, kind_nx;
  logic [tcp_pkg::CharW-1:0] first_q, first_d, first_nx;
  logic                      minus_q, minus_d, minus_nx;
  logic                      digit_q, digit_d, digit_nx;
  logic [tcp_pkg::ValW-1:0]  acc_q, acc_d, acc_nx;
  logic [1:0]                frac_q, frac_d, frac_nx;

  logic [tcp_pkg::CharW-1:0] up0, up1;
  logic [3:0]                dig;
  logic [30:0]               int_sum;
  logic [27:0]               frac_sum;
  logic [tcp_pkg::ValW-1:0]  int_sat, frac_sat;
  logic                      in_value, is_sep, is_blank, is_digit;

  function automatic logic [tcp_pkg::CharW-1:0] to_upper(input logic [tcp_pkg::CharW-1:0] c);
    logic [tcp_pkg::CharW-1:0] r;
    r = c;
    if (c >= tcp_pkg::ChLoA && c <= tcp_pkg::ChLoZ) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  function automatic logic [6:0] frac_weight(input logic [1:0] n);
    logic [6:0] w;
    case (n)
      2'd0:    w = 7'd100;
      2'd1:    w = 7'd10;
      default: w = 7'd1;
    endcase
    return w;
  endfunction

  always_comb begin
    up0      = to_upper(first_q);
    up1      = to_upper(char_i);
    dig      = 4'(char_i - tcp_pkg::Ch0);
    is_sep   = (char_i == tcp_pkg::ChEqual) || (char_i == tcp_pkg::ChColon);
    is_blank = (char_i == tcp_pkg::ChSpace) || (char_i == tcp_pkg::ChTab);
    is_digit = (char_i >= tcp_pkg::Ch0) && (char_i <= tcp_pkg::Ch9);
    in_value = phase_q inside {[tcp_pkg::PhLead:tcp_pkg::PhTrail]};

    // value * 10 + digit * 1000, and value + digit * fraction weight
    int_sum  = 31'({acc_q, 3'b000}) + 31'({acc_q, 1'b0}) + 31'(14'(dig) * 14'd1000);
    frac_sum = 28'(acc_q) + 28'(10'(dig) * 10'(frac_weight(frac_q)));
    int_sat  = (int_sum > 31'(tcp_pkg::SatValue)) ? tcp_pkg::SatValue : int_sum[26:0];
    frac_sat = (frac_sum > 28'(tcp_pkg::SatValue)) ? tcp_pkg::SatValue : frac_sum[26:0];

    pos_nx   = pos_q;
    phase_nx = phase_q;
    kind_nx  = kind_q;
    first_nx = first_q;
    minus_nx = minus_q;
    digit_nx = digit_q;
    acc_nx   = acc_q;
    frac_nx  = frac_q;

    if (phase_q != tcp_pkg::PhDone && phase_q != tcp_pkg::PhBad) begin
      if (pos_q >= tcp_pkg::PosW'(tcp_pkg::MaxCommandChars)) begin
        phase_nx = tcp_pkg::PhBad;
      end else begin
        pos_nx = pos_q + tcp_pkg::PosW'(1);
        if (char_i == tcp_pkg::ChNul) begin
          phase_nx = (in_value && digit_q) ? tcp_pkg::PhDone : tcp_pkg::PhBad;
        end else if (phase_q == tcp_pkg::PhHead) begin
          if (pos_q == '0) begin
            first_nx = char_i;
          end else if (pos_q == tcp_pkg::PosW'(1)) begin
            if (first_q == tcp_pkg::ChLoK &&
                (char_i == tcp_pkg::ChLoP || char_i == tcp_pkg::ChLoI)) begin
              kind_nx = tcp_pkg::KindLine;
            end else if (up0 == tcp_pkg::ChUpS) begin
              phase_nx = is_sep ? tcp_pkg::PhLead : tcp_pkg::PhBad;
              kind_nx  = tcp_pkg::KindSpeed;
            end else if (up0 == tcp_pkg::ChUpK && up1 == tcp_pkg::ChUpP) begin
              kind_nx = tcp_pkg::KindP;
            end else if (up0 == tcp_pkg::ChUpK && up1 == tcp_pkg::ChUpI) begin
              kind_nx = tcp_pkg::KindI;
            end else if (up0 == tcp_pkg::ChUpK && up1 == tcp_pkg::ChUpD) begin
              kind_nx = tcp_pkg::KindD;
            end else begin
              phase_nx = tcp_pkg::PhBad;
            end
          end else begin
            phase_nx = is_sep ? tcp_pkg::PhLead : tcp_pkg::PhBad;
          end
        end else begin
          if (is_digit && phase_q != tcp_pkg::PhTrail) begin
            digit_nx = 1'b1;
            if (phase_q == tcp_pkg::PhFrac) begin
              if (int'(frac_q) < tcp_pkg::FractionDigits) begin
                acc_nx = frac_sat;
              end
              if (frac_q != 2'd3) begin
                frac_nx = frac_q + 2'd1;
              end
            end else begin
              acc_nx   = int_sat;
              phase_nx = tcp_pkg::PhInt;
            end
          end else if (char_i == tcp_pkg::ChDot && phase_q != tcp_pkg::PhFrac &&
                       phase_q != tcp_pkg::PhTrail) begin
            phase_nx = tcp_pkg::PhFrac;
          end else if (is_blank) begin
            if (phase_q != tcp_pkg::PhLead) begin
              phase_nx = tcp_pkg::PhTrail;
            end
          end else if ((char_i == tcp_pkg::ChPlus || char_i == tcp_pkg::ChMinus) &&
                       phase_q == tcp_pkg::PhLead) begin
            minus_nx = (char_i == tcp_pkg::ChMinus);
            phase_nx = tcp_pkg::PhSign;
          end else begin
            phase_nx = tcp_pkg::PhBad;
          end
        end
      end
    end

    // hold between requests, restart after the last character
    pos_d   = pos_q;
    phase_d = phase_q;
    kind_d  = kind_q;
    first_d = first_q;
    minus_d = minus_q;
    digit_d = digit_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    if (take_i) begin
      if (final_i) begin
        pos_d   = '0;
        phase_d = tcp_pkg::PhHead;
        kind_d  = tcp_pkg::KindNone;
        first_d = '0;
        minus_d = 1'b0;
        digit_d = 1'b0;
        acc_d   = '0;
        frac_d  = '0;
      end else begin
        pos_d   = pos_nx;
        phase_d = phase_nx;
        kind_d  = kind_nx;
        first_d = first_nx;
        minus_d = minus_nx;
        digit_d = digit_nx;
        acc_d   = acc_nx;
        frac_d  = frac_nx;
      end
    end

    snap_o.ok    = (phase_nx == tcp_pkg::PhDone) ||
                   ((phase_nx inside {[tcp_pkg::PhLead:tcp_pkg::PhTrail]}) && digit_nx);
    snap_o.minus = minus_nx;
    snap_o.kind  = kind_nx;
    snap_o.value = acc_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= tcp_pkg::PhHead;
      kind_q  <= tcp_pkg::KindNone;
      first_q <= '0;
      minus_q <= 1'b0;
      digit_q <= 1'b0;
      acc_q   <= '0;
      frac_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
      first_q <= first_d;
      minus_q <= minus_d;
      digit_q <= digit_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
    end
  end

endmodule

/* rtl/tcp_judge.sv */
// ----------------------------------------------------------------------------
// tcp_judge
// sign and limit checks that turn a parsed command into a verdict and amount
// ----------------------------------------------------------------------------
module tcp_judge (
  input  tcp_pkg::snap_t                 snap_i,
  input  logic [tcp_pkg::ValW-1:0]       line_gain_limit_i,
  input  logic [tcp_pkg::ValW-1:0]       speed_gain_limit_i,
  input  logic [tcp_pkg::ValW-1:0]       speed_limit_i,
  output tcp_pkg::out_res_t              res_o
);

  logic ok;

  always_comb begin
    ok            = snap_i.ok && !(snap_i.minus && snap_i.value != '0);
    res_o.verdict = tcp_pkg::VerdictReject;
    res_o.amount  = '0;
    if (ok) begin
      case (snap_i.kind)
        tcp_pkg::KindLine: begin
          if (snap_i.value <= line_gain_limit_i) begin
            res_o.verdict = tcp_pkg::VerdictLine;
            res_o.amount  = snap_i.value;
          end
        end
        tcp_pkg::KindP, tcp_pkg::KindI, tcp_pkg::KindD: begin
          if (snap_i.value <= speed_gain_limit_i) begin
            res_o.verdict = snap_i.kind;
            res_o.amount  = snap_i.value;
          end
        end
        tcp_pkg::KindSpeed: begin
          if (snap_i.value <= speed_limit_i) begin
            res_o.verdict = (snap_i.value == '0) ? tcp_pkg::VerdictStop : tcp_pkg::VerdictRun;
            res_o.amount  = snap_i.value;
          end
        end
        default: begin
          res_o.verdict = tcp_pkg::VerdictReject;
        end
      endcase
    end
  end

endmodule

/* rtl/tuning_command_parser.sv */
// ----------------------------------------------------------------------------
// tuning_command_parser
// streaming parser for ASCII tuning commands (line gain, speed gains, speed)
// ----------------------------------------------------------------------------
// Input channel: one character per request (in_req_i.char_in), with
// in_req_i.final_char marking the last character of a command. A request is
// taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: one result per command (verdict and amount in thousandths),
// taken at an edge with out_valid_o high and out_stall_i low.
// Throughput: one character per cycle while in_stall_o is low; the parse
// state is updated as each character arrives, so a command waits on the one
// before it only while in_stall_o is high. A command is held in the command
// register behind the parser as its final character is taken, then its
// result in the result register behind the limit checks once that can load.
// Stall: while the result register is full and stalled, one more finished
// command can wait in the command register; in_stall_o rises only when that
// is full too, and falls as soon as the result is taken. Reset: all parse
// state clears, no result is pending, and the three limit registers return
// to 100000. Limits are written via cfg_we_i while idle, a rule the user keeps.
// ----------------------------------------------------------------------------
module tuning_command_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tcp_pkg::in_req_t          in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tcp_pkg::out_res_t         out_res_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [tcp_pkg::ValW-1:0]  cfg_data_i
);

  logic                     take, out_load, snap_adv;
  logic                     snap_valid_q, snap_valid_d;
  logic                     out_valid_q, out_valid_d;
  tcp_pkg::snap_t           snap_nx, snap_q;
  tcp_pkg::out_res_t        res, res_q;
  logic [tcp_pkg::ValW-1:0] line_lim_q, speed_gain_lim_q, speed_lim_q;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign snap_adv   = snap_valid_q && out_load;
  assign in_stall_o = snap_valid_q && !out_load;
  assign take       = in_valid_i && !in_stall_o;

  tcp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .char_i  (in_req_i.char_in),
    .final_i (in_req_i.final_char),
    .snap_o  (snap_nx)
  );

  tcp_judge u_judge (
    .snap_i             (snap_q),
    .line_gain_limit_i  (line_lim_q),
    .speed_gain_limit_i (speed_gain_lim_q),
    .speed_limit_i      (speed_lim_q),
    .res_o              (res)
  );

  always_comb begin
    snap_valid_d = snap_valid_q;
    if (take && in_req_i.final_char) begin
      snap_valid_d = 1'b1;
    end else if (snap_adv) begin
      snap_valid_d = 1'b0;
    end
    out_valid_d = out_load ? snap_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q     <= 1'b0;
      out_valid_q      <= 1'b0;
      line_lim_q       <= tcp_pkg::LimitReset;
      speed_gain_lim_q <= tcp_pkg::LimitReset;
      speed_lim_q      <= tcp_pkg::LimitReset;
    end else begin
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcp_pkg::CfgLineGainLimit:  line_lim_q       <= cfg_data_i;
          tcp_pkg::CfgSpeedGainLimit: speed_gain_lim_q <= cfg_data_i;
          tcp_pkg::CfgSpeedLimit:     speed_lim_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take && in_req_i.final_char) begin
      snap_q <= snap_nx;
    end
    if (snap_adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

/* rtl/tcp_checker.sv */
// ----------------------------------------------------------------------------
// tcp_checker
// port-level checks of the tuning command parser, bound to the top level
// ----------------------------------------------------------------------------
module tcp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tcp_pkg::out_res_t out_res_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // input backs up only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.verdict <= tcp_pkg::VerdictStop)
    else $error("verdict code out of range");

  // reject and stop carry no amount
  a_zero_amount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.verdict == tcp_pkg::VerdictReject ||
                    out_res_o.verdict == tcp_pkg::VerdictStop)
    |-> out_res_o.amount == '0)
    else $error("nonzero amount on reject or stop");

endmodule

bind tuning_command_parser tcp_checker u_tcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
